>>> rtl/core/hex_lagrange_node_coords_defines.svh
// Assertion macros shared by the node-coordinate block.
`ifndef HEX_LAGRANGE_NODE_COORDS_DEFINES_SVH
`define HEX_LAGRANGE_NODE_COORDS_DEFINES_SVH
`ifndef ASSERT_OFF
// Property checked at every rising clock edge outside reset.
`define HLNC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hlnc: assertion failed");
// Consequent checked in the cycle after the antecedent, outside reset.
`define HLNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hlnc: assertion failed");
`else
`define HLNC_ASSERT(lbl, clk, rst_n, prop)
`define HLNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/hlnc_pkg.sv
// Types, constants and lookup functions of the hexahedron node-coordinate block.
package hlnc_pkg;

  localparam int unsigned MAX_ORDER_DEF = 15;
  localparam int unsigned IDX_W         = 12;
  localparam int unsigned ORD_W         = 4;
  localparam int unsigned STEP_W        = 4;
  localparam int unsigned N_CORNERS     = 8;

  // Reciprocals are ceil(2^RCP_SHIFT / d); exact for 12-bit dividends and d <= 196.
  localparam int unsigned RCP_SHIFT = 20;
  localparam int unsigned RCP_W     = 21;

  typedef enum logic [1:0] {
    KIND_CORNER,
    KIND_EDGE,
    KIND_FACE,
    KIND_INNER
  } node_kind_t;

  typedef enum logic [1:0] {
    AX_LO,
    AX_HI,
    AX_RUN,
    AX_SLOW
  } ax_sel_t;

  typedef struct packed {
    ax_sel_t x;
    ax_sel_t y;
    ax_sel_t z;
  } sel3_t;

  // Everything derived from the element order, held in one register.
  typedef struct packed {
    logic [ORD_W-1:0] n;
    logic [3:0]       m;
    logic [7:0]       mm;
    logic [12:0]      total;
    logic [7:0]       face_base;
    logic [10:0]      inner_base;
    logic [RCP_W-1:0] rcp_m;
    logic [RCP_W-1:0] rcp_mm;
  } ord_info_t;

  // Classification that travels with a word down the pipeline.
  typedef struct packed {
    logic       ok;
    node_kind_t kind;
    logic [2:0] corner;
  } tag_t;

  // Tag plus the first quotient (edge, face or layer number).
  typedef struct packed {
    tag_t       tag;
    logic [3:0] q1;
  } tag2_t;

  // Derived values for an order already clamped to 1..15.
  function automatic ord_info_t order_info(input logic [ORD_W-1:0] n);
    ord_info_t info;
    unique case (n)
      4'd2:  info = '{4'd2,  4'd1,  8'd1,   13'd27,   8'd20,  11'd26,   21'd1048576, 21'd1048576};
      4'd3:  info = '{4'd3,  4'd2,  8'd4,   13'd64,   8'd32,  11'd56,   21'd524288,  21'd262144};
      4'd4:  info = '{4'd4,  4'd3,  8'd9,   13'd125,  8'd44,  11'd98,   21'd349526,  21'd116509};
      4'd5:  info = '{4'd5,  4'd4,  8'd16,  13'd216,  8'd56,  11'd152,  21'd262144,  21'd65536};
      4'd6:  info = '{4'd6,  4'd5,  8'd25,  13'd343,  8'd68,  11'd218,  21'd209716,  21'd41944};
      4'd7:  info = '{4'd7,  4'd6,  8'd36,  13'd512,  8'd80,  11'd296,  21'd174763,  21'd29128};
      4'd8:  info = '{4'd8,  4'd7,  8'd49,  13'd729,  8'd92,  11'd386,  21'd149797,  21'd21400};
      4'd9:  info = '{4'd9,  4'd8,  8'd64,  13'd1000, 8'd104, 11'd488,  21'd131072,  21'd16384};
      4'd10: info = '{4'd10, 4'd9,  8'd81,  13'd1331, 8'd116, 11'd602,  21'd116509,  21'd12946};
      4'd11: info = '{4'd11, 4'd10, 8'd100, 13'd1728, 8'd128, 11'd728,  21'd104858,  21'd10486};
      4'd12: info = '{4'd12, 4'd11, 8'd121, 13'd2197, 8'd140, 11'd866,  21'd95326,   21'd8666};
      4'd13: info = '{4'd13, 4'd12, 8'd144, 13'd2744, 8'd152, 11'd1016, 21'd87382,   21'd7282};
      4'd14: info = '{4'd14, 4'd13, 8'd169, 13'd3375, 8'd164, 11'd1178, 21'd80660,   21'd6205};
      4'd15: info = '{4'd15, 4'd14, 8'd196, 13'd4096, 8'd176, 11'd1352, 21'd74899,   21'd5350};
      // Order one: corners only.
      default: info = '{4'd1, 4'd0, 8'd0, 13'd8, 8'd8, 11'd8, 21'd0, 21'd0};
    endcase
    return info;
  endfunction

  // Which axis runs along each edge; vertical edges sit at (0,0), (n,0), (0,n), (n,n).
  function automatic sel3_t edge_sel(input logic [3:0] e);
    sel3_t s;
    unique case (e)
      4'd0:    s = '{AX_RUN, AX_LO,  AX_LO};
      4'd1:    s = '{AX_HI,  AX_RUN, AX_LO};
      4'd2:    s = '{AX_RUN, AX_HI,  AX_LO};
      4'd3:    s = '{AX_LO,  AX_RUN, AX_LO};
      4'd4:    s = '{AX_RUN, AX_LO,  AX_HI};
      4'd5:    s = '{AX_HI,  AX_RUN, AX_HI};
      4'd6:    s = '{AX_RUN, AX_HI,  AX_HI};
      4'd7:    s = '{AX_LO,  AX_RUN, AX_HI};
      4'd8:    s = '{AX_LO,  AX_LO,  AX_RUN};
      4'd9:    s = '{AX_HI,  AX_LO,  AX_RUN};
      4'd10:   s = '{AX_LO,  AX_HI,  AX_RUN};
      4'd11:   s = '{AX_HI,  AX_HI,  AX_RUN};
      default: s = '{AX_LO,  AX_LO,  AX_LO};
    endcase
    return s;
  endfunction

  // Fixed axis and in-face fast and slow axes of each face.
  function automatic sel3_t face_sel(input logic [3:0] f);
    sel3_t s;
    unique case (f)
      4'd0:    s = '{AX_LO,  AX_RUN,  AX_SLOW};
      4'd1:    s = '{AX_HI,  AX_RUN,  AX_SLOW};
      4'd2:    s = '{AX_RUN, AX_LO,   AX_SLOW};
      4'd3:    s = '{AX_RUN, AX_HI,   AX_SLOW};
      4'd4:    s = '{AX_RUN, AX_SLOW, AX_LO};
      4'd5:    s = '{AX_RUN, AX_SLOW, AX_HI};
      default: s = '{AX_LO,  AX_LO,   AX_LO};
    endcase
    return s;
  endfunction

  function automatic logic [STEP_W-1:0] pick(input ax_sel_t sel,
                                             input logic [STEP_W-1:0] n,
                                             input logic [STEP_W-1:0] run,
                                             input logic [STEP_W-1:0] slow);
    logic [STEP_W-1:0] v;
    unique case (sel)
      AX_LO:   v = '0;
      AX_HI:   v = n;
      AX_RUN:  v = run;
      AX_SLOW: v = slow;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/hex_lagrange_node_coords.sv
// A word accepted at the input passes six register stages: classify, two in each
// divider, and assemble. Throughput: one word per cycle while the result side does
// not stall, set by the six-stage pipeline with one reciprocal multiply or
// back-multiply per stage in its two dividers.
// A stall of the result side while a result is valid holds every stage; bubbles hold with it.
// Synchronous active-low reset clears all valid bits and sets the order to one.
`include "hex_lagrange_node_coords_defines.svh"

module hex_lagrange_node_coords #(
  parameter int unsigned MAX_ORDER = hlnc_pkg::MAX_ORDER_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hlnc_pkg::IDX_W-1:0]   in_point_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hlnc_pkg::STEP_W-1:0]  out_x_step,
  output logic [hlnc_pkg::STEP_W-1:0]  out_y_step,
  output logic [hlnc_pkg::STEP_W-1:0]  out_z_step,
  output logic                         out_index_valid,
  input  logic                         cfg_we,
  input  logic [hlnc_pkg::ORD_W-1:0]   cfg_wdata
);
  import hlnc_pkg::*;

  localparam int unsigned SW1 = $bits(tag_t);
  localparam int unsigned SW2 = $bits(tag2_t);

  ord_info_t         ord_r, ord_nxt;
  logic [ORD_W-1:0]  ord_n;
  logic              adv;

  logic              s1_vld;
  tag_t              s1_tag;
  logic [IDX_W-1:0]  s1_off;
  logic [7:0]        s1_div;
  logic [RCP_W-1:0]  s1_rcp;

  logic              d1_vld;
  logic [3:0]        d1_quo;
  logic [7:0]        d1_rem;
  logic [SW1-1:0]    d1_side;
  tag2_t             d1_tag2;

  logic              d2_vld;
  logic [3:0]        d2_quo;
  logic [3:0]        d2_rem;
  logic [SW2-1:0]    d2_side;

  logic              in_lattice;
  logic              all_zero;
  logic              order_legal;

  // Order zero acts as one; orders above the limit saturate.
  always_comb begin
    priority if (cfg_wdata == '0) begin
      ord_n = ORD_W'(1);
    end else if (int'(cfg_wdata) > int'(MAX_ORDER)) begin
      ord_n = ORD_W'(MAX_ORDER);
    end else begin
      ord_n = cfg_wdata;
    end
    ord_nxt = cfg_we ? order_info(ord_n) : ord_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r <= order_info(ORD_W'(1));
    end else begin
      ord_r <= ord_nxt;
    end
  end

  // The whole pipeline moves unless a finished word is held at the output.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  hlnc_classify u_classify (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_valid),
    .in_point_index (in_point_index),
    .ord            (ord_r),
    .s1_vld         (s1_vld),
    .s1_tag         (s1_tag),
    .s1_off         (s1_off),
    .s1_div         (s1_div),
    .s1_rcp         (s1_rcp)
  );

  // Offset over (n-1) or (n-1)^2: edge, face or layer number and remainder.
  hlnc_rdiv #(
    .DW (IDX_W),
    .VW (8),
    .QW (4),
    .SW (SW1)
  ) u_div_outer (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (s1_vld),
    .in_num   (s1_off),
    .in_div   (s1_div),
    .in_rcp   (s1_rcp),
    .in_side  (s1_tag),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_rem  (d1_rem),
    .out_side (d1_side)
  );

  assign d1_tag2.tag = tag_t'(d1_side);
  assign d1_tag2.q1  = d1_quo;

  // Remainder over (n-1): fast and slow in-plane positions.
  hlnc_rdiv #(
    .DW (8),
    .VW (4),
    .QW (4),
    .SW (SW2)
  ) u_div_inner (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (d1_vld),
    .in_num   (d1_rem),
    .in_div   (ord_r.m),
    .in_rcp   (ord_r.rcp_m),
    .in_side  (d1_tag2),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_rem  (d2_rem),
    .out_side (d2_side)
  );

  hlnc_assemble u_assemble (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_vld          (d2_vld),
    .in_tag          (tag2_t'(d2_side)),
    .in_q2           (d2_quo),
    .in_r2           (d2_rem),
    .n               (ord_r.n),
    .out_valid       (out_valid),
    .out_x_step      (out_x_step),
    .out_y_step      (out_y_step),
    .out_z_step      (out_z_step),
    .out_index_valid (out_index_valid)
  );

  // Terms of the checks below.
  assign in_lattice  = (out_x_step <= ord_r.n) && (out_y_step <= ord_r.n) &&
                       (out_z_step <= ord_r.n);
  assign all_zero    = (out_x_step | out_y_step | out_z_step) == '0;
  assign order_legal = (cfg_wdata != '0) && (int'(cfg_wdata) <= int'(MAX_ORDER));

  `HLNC_ASSERT(a_order_nonzero, clk, rst_n, ord_r.n != '0)
  `HLNC_ASSERT(a_steps_in_lattice, clk, rst_n, !(out_valid && out_index_valid) || in_lattice)
  `HLNC_ASSERT(a_invalid_is_zero, clk, rst_n, !(out_valid && !out_index_valid) || all_zero)
  `HLNC_ASSERT_NEXT(a_order_written, clk, rst_n, cfg_we && order_legal, ord_r.n == $past(cfg_wdata))

endmodule

>>> rtl/core/hlnc_classify.sv
// First pipeline stage: range check, region decode and offset within the region.
module hlnc_classify (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [hlnc_pkg::IDX_W-1:0]  in_point_index,
  input  hlnc_pkg::ord_info_t         ord,
  output logic                        s1_vld,
  output hlnc_pkg::tag_t              s1_tag,
  output logic [hlnc_pkg::IDX_W-1:0]  s1_off,
  output logic [7:0]                  s1_div,
  output logic [hlnc_pkg::RCP_W-1:0]  s1_rcp
);
  import hlnc_pkg::*;

  logic                 vld_r;
  tag_t                 tag_r, tag_nxt;
  logic [IDX_W-1:0]     off_r, off_nxt;
  logic [7:0]           div_r, div_nxt;
  logic [RCP_W-1:0]     rcp_r, rcp_nxt;
  logic [IDX_W-1:0]     base;

  // Decode the region; edges divide by n-1, faces and interior by (n-1)^2.
  always_comb begin
    tag_nxt.ok     = ({1'b0, in_point_index} < ord.total);
    tag_nxt.corner = in_point_index[2:0];
    div_nxt        = ord.mm;
    rcp_nxt        = ord.rcp_mm;
    priority if (in_point_index < IDX_W'(N_CORNERS)) begin
      tag_nxt.kind = KIND_CORNER;
      base         = '0;
    end else if (in_point_index < {4'd0, ord.face_base}) begin
      tag_nxt.kind = KIND_EDGE;
      base         = IDX_W'(N_CORNERS);
      div_nxt      = {4'd0, ord.m};
      rcp_nxt      = ord.rcp_m;
    end else if (in_point_index < {1'b0, ord.inner_base}) begin
      tag_nxt.kind = KIND_FACE;
      base         = {4'd0, ord.face_base};
    end else begin
      tag_nxt.kind = KIND_INNER;
      base         = {1'b0, ord.inner_base};
    end
    off_nxt = in_point_index - base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r <= tag_nxt;
      off_r <= off_nxt;
      div_r <= div_nxt;
      rcp_r <= rcp_nxt;
    end
  end

  assign s1_vld = vld_r;
  assign s1_tag = tag_r;
  assign s1_off = off_r;
  assign s1_div = div_r;
  assign s1_rcp = rcp_r;

endmodule

>>> rtl/core/hlnc_rdiv.sv
// Two-stage divider: reciprocal multiply, then back-multiply for the remainder.
module hlnc_rdiv #(
  parameter int unsigned DW = 12,
  parameter int unsigned VW = 8,
  parameter int unsigned QW = 4,
  parameter int unsigned SW = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [DW-1:0]               in_num,
  input  logic [VW-1:0]               in_div,
  input  logic [hlnc_pkg::RCP_W-1:0]  in_rcp,
  input  logic [SW-1:0]               in_side,
  output logic                        out_vld,
  output logic [QW-1:0]               out_quo,
  output logic [VW-1:0]               out_rem,
  output logic [SW-1:0]               out_side
);
  import hlnc_pkg::*;

  localparam int unsigned PROD_W = DW + RCP_W;
  localparam int unsigned BACK_W = DW + VW;

  logic [PROD_W-1:0] prod;
  logic [BACK_W-1:0] back;
  logic [DW-1:0]     rem_full;

  logic              vld_a_r, vld_b_r;
  logic [DW-1:0]     quo_a_r;
  logic [DW-1:0]     num_a_r;
  logic [VW-1:0]     div_a_r;
  logic [SW-1:0]     side_a_r, side_b_r;
  logic [QW-1:0]     quo_b_r;
  logic [VW-1:0]     rem_b_r;

  // Quotient estimate is exact for the dividend and divisor ranges in use.
  assign prod = {{RCP_W{1'b0}}, in_num} * {{DW{1'b0}}, in_rcp};

  // Remainder from the registered quotient.
  assign back     = {{VW{1'b0}}, quo_a_r} * {{DW{1'b0}}, div_a_r};
  assign rem_full = num_a_r - back[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quo_a_r  <= prod[RCP_SHIFT +: DW];
      num_a_r  <= in_num;
      div_a_r  <= in_div;
      side_a_r <= in_side;
      quo_b_r  <= quo_a_r[QW-1:0];
      rem_b_r  <= rem_full[VW-1:0];
      side_b_r <= side_a_r;
    end
  end

  assign out_vld  = vld_b_r;
  assign out_quo  = quo_b_r;
  assign out_rem  = rem_b_r;
  assign out_side = side_b_r;

endmodule

>>> rtl/core/hlnc_assemble.sv
// Last stage: builds the lattice position from region, quotients and remainder.
module hlnc_assemble (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  hlnc_pkg::tag2_t              in_tag,
  input  logic [3:0]                   in_q2,
  input  logic [3:0]                   in_r2,
  input  logic [hlnc_pkg::ORD_W-1:0]   n,
  output logic                         out_valid,
  output logic [hlnc_pkg::STEP_W-1:0]  out_x_step,
  output logic [hlnc_pkg::STEP_W-1:0]  out_y_step,
  output logic [hlnc_pkg::STEP_W-1:0]  out_z_step,
  output logic                         out_index_valid
);
  import hlnc_pkg::*;

  logic              vld_r;
  logic [STEP_W-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic              ok_r;
  logic [STEP_W-1:0] run, slow;
  sel3_t             esel, fsel;

  assign run  = in_r2 + 4'd1;
  assign slow = in_q2 + 4'd1;
  assign esel = edge_sel(in_tag.q1);
  assign fsel = face_sel(in_tag.q1);

  // Select the position by region; a word past the lattice gives zeros.
  always_comb begin
    unique case (in_tag.tag.kind)
      KIND_CORNER: begin
        x_nxt = (in_tag.tag.corner[0] ^ in_tag.tag.corner[1]) ? n : '0;
        y_nxt = in_tag.tag.corner[1] ? n : '0;
        z_nxt = in_tag.tag.corner[2] ? n : '0;
      end
      KIND_EDGE: begin
        x_nxt = pick(esel.x, n, run, '0);
        y_nxt = pick(esel.y, n, run, '0);
        z_nxt = pick(esel.z, n, run, '0);
      end
      KIND_FACE: begin
        x_nxt = pick(fsel.x, n, run, slow);
        y_nxt = pick(fsel.y, n, run, slow);
        z_nxt = pick(fsel.z, n, run, slow);
      end
      KIND_INNER: begin
        x_nxt = run;
        y_nxt = slow;
        z_nxt = in_tag.q1 + 4'd1;
      end
    endcase
    if (!in_tag.tag.ok) begin
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      ok_r <= in_tag.tag.ok;
    end
  end

  assign out_valid       = vld_r;
  assign out_x_step      = x_r;
  assign out_y_step      = y_r;
  assign out_z_step      = z_r;
  assign out_index_valid = ok_r;

endmodule
